FILE: rtl/qsvc_pkg.sv
// Shared constants and types for the quorum shift vote collector.
package qsvc_pkg;

	localparam int TABLE_DEPTH  = 8;
	localparam int MAX_REPLICAS = 64;

	localparam int HEIGHT_W = 32;
	localparam int SHIFT_W  = 3;
	localparam int ID_W     = 6;
	localparam int COUNT_W  = $clog2(MAX_REPLICAS + 1);
	localparam int NREP_W   = 7;
	localparam int FLIM_W   = 6;
	localparam int KEY_W    = HEIGHT_W + SHIFT_W;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_REPLICA_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FAULT_LIMIT   = 1'd1;

	// Broadcast from the controller to every entry cell.
	typedef struct packed {
		logic                load;
		logic                upd;
		logic                clr;
		logic [HEIGHT_W-1:0] height;
		logic [SHIFT_W-1:0]  shift;
		logic [ID_W-1:0]     id;
	} qsvc_cmd_t;

	// Ripples from each cell to its right-hand neighbor.
	typedef struct packed {
		logic hit;
		logic free;
	} qsvc_chain_t;

	// Status from one cell back to the controller.
	typedef struct packed {
		logic               sel;
		logic [COUNT_W-1:0] cnt;
	} qsvc_stat_t;

endpackage

FILE: rtl/qsvc_entry_cell.sv
// One table entry cell: holds a key, its voter bitmap and its voter count.
module qsvc_entry_cell import qsvc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  qsvc_cmd_t   cmd,
	input  logic        any_hit,
	input  qsvc_chain_t chain_in,
	output qsvc_chain_t chain_out,
	output qsvc_stat_t  stat
);

	logic                    valid_q;
	logic                    sel_q;
	logic [HEIGHT_W-1:0]     height_q;
	logic [SHIFT_W-1:0]      shift_q;
	logic [MAX_REPLICAS-1:0] voters_q;
	logic [COUNT_W-1:0]      cnt_q;

	logic [KEY_W-1:0]        own_key;
	logic [KEY_W-1:0]        vote_key;
	logic                    key_eq;
	logic                    key_le;
	logic                    claim;
	logic                    write_en;
	logic                    id_ok;
	logic [MAX_REPLICAS-1:0] id_mask;
	logic                    new_bit;

	assign own_key  = {height_q, shift_q};
	assign vote_key = {cmd.height, cmd.shift};
	assign key_eq   = valid_q && (own_key == vote_key);
	assign key_le   = valid_q && (own_key <= vote_key);

	// The lowest free cell claims a new key when no cell holds it already.
	assign claim    = !valid_q && !chain_in.free && !any_hit;
	assign write_en = cmd.upd && (key_eq || claim);

	assign id_ok   = ({1'b0, cmd.id} < (ID_W + 1)'(MAX_REPLICAS));
	assign id_mask = id_ok ? (MAX_REPLICAS'(1) << cmd.id) : '0;
	assign new_bit = |(id_mask & ~voters_q);

	assign chain_out.hit  = chain_in.hit | key_eq;
	assign chain_out.free = chain_in.free | !valid_q;

	assign stat.sel = sel_q;
	assign stat.cnt = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				sel_q <= write_en;
			end
			if (write_en) begin
				valid_q <= 1'b1;
			end else if (cmd.clr && key_le) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (write_en) begin
			if (claim) begin
				height_q <= cmd.height;
				shift_q  <= cmd.shift;
				voters_q <= id_mask;
				cnt_q    <= COUNT_W'(id_ok);
			end else begin
				voters_q <= voters_q | id_mask;
				cnt_q    <= cnt_q + COUNT_W'(new_bit);
			end
		end
	end

endmodule

FILE: rtl/quorum_shift_vote_collector_unit.sv
// Each accepted request is registered and walks through a table update phase and a
// tally and clear phase, and its result is registered on the output; the controller
// takes the next request only after that, and the tally waits on a stalled output.
// A request may be accepted while the previous result still waits on the output.
// Reset clears the agreed key to zero, empties the table at once and restores the
// registers to four replicas and a fault limit of one.
module quorum_shift_vote_collector_unit import qsvc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [HEIGHT_W-1:0]   vote_height,
	input  logic [SHIFT_W-1:0]    vote_shift_index,
	input  logic [ID_W-1:0]       voter_id,

	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  stale_vote,
	output logic                  table_full_drop,
	output logic [COUNT_W-1:0]    vote_count,
	output logic                  quorum_reached,
	output logic [HEIGHT_W-1:0]   agreed_height,
	output logic [SHIFT_W-1:0]    agreed_shift_index,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// The controller steps through three phases. In the update phase every cell
	// compares its key with the request in parallel; unless the request is stale,
	// the matching cell, or else the lowest free cell found through the neighbor
	// chain, records the voter and bumps its running count. In the tally phase the
	// selected count is checked against the quorum threshold, and on a quorum every
	// cell whose key is not above the request's key drops out of the table.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_TALLY
	} state_t;

	state_t              state_q;
	logic [HEIGHT_W-1:0] vote_height_q;
	logic [SHIFT_W-1:0]  vote_shift_q;
	logic [ID_W-1:0]     voter_id_q;
	logic [NREP_W-1:0]   replica_count_q;
	logic [FLIM_W-1:0]   fault_limit_q;
	logic                stale_q;
	logic                drop_q;
	logic                out_valid_q;
	logic                out_stale_q;
	logic                out_drop_q;
	logic [COUNT_W-1:0]  out_count_q;
	logic                out_quorum_q;
	logic [HEIGHT_W-1:0] agreed_height_q;
	logic [SHIFT_W-1:0]  agreed_shift_q;

	qsvc_cmd_t           cmd;
	qsvc_chain_t         chain [TABLE_DEPTH+1];
	qsvc_stat_t          stat [TABLE_DEPTH];

	logic                accept;
	logic                out_free;
	logic                vote_stale;
	logic [NREP_W-1:0]   threshold;
	logic [COUNT_W-1:0]  sel_count;
	logic                any_sel;
	logic                quorum;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	assign vote_stale = {vote_height_q, vote_shift_q} < {agreed_height_q, agreed_shift_q};

	// The threshold is n - f, and one whenever the fault limit reaches n.
	assign threshold = ({1'b0, fault_limit_q} >= replica_count_q) ?
		NREP_W'(1) : replica_count_q - {1'b0, fault_limit_q};

	// At most one cell is selected, so a plain OR picks its count.
	always_comb begin
		sel_count = '0;
		any_sel   = 1'b0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			sel_count = sel_count | (stat[i].sel ? stat[i].cnt : '0);
			any_sel   = any_sel | stat[i].sel;
		end
	end

	// A threshold above the number of replicas the table can track is never met.
	assign quorum = any_sel && (sel_count >= threshold);

	assign cmd.load   = (state_q == ST_UPDATE);
	assign cmd.upd    = (state_q == ST_UPDATE) && !vote_stale;
	assign cmd.clr    = (state_q == ST_TALLY) && out_free && quorum;
	assign cmd.height = vote_height_q;
	assign cmd.shift  = vote_shift_q;
	assign cmd.id     = voter_id_q;

	assign chain[0] = '0;

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		qsvc_entry_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.any_hit   (chain[TABLE_DEPTH].hit),
			.chain_in  (chain[g]),
			.chain_out (chain[g+1]),
			.stat      (stat[g])
		);
	end

	// The request payload is held for the whole walk through the phases.
	always_ff @(posedge clk) begin
		if (accept) begin
			vote_height_q <= vote_height;
			vote_shift_q  <= vote_shift_index;
			voter_id_q    <= voter_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replica_count_q <= NREP_W'(4);
			fault_limit_q   <= FLIM_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_REPLICA_COUNT: replica_count_q <= cfg_data[NREP_W-1:0];
				REG_FAULT_LIMIT:   fault_limit_q   <= cfg_data[FLIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			stale_q         <= 1'b0;
			drop_q          <= 1'b0;
			out_valid_q     <= 1'b0;
			out_stale_q     <= 1'b0;
			out_drop_q      <= 1'b0;
			out_count_q     <= '0;
			out_quorum_q    <= 1'b0;
			agreed_height_q <= '0;
			agreed_shift_q  <= '0;
		end else begin
			// A new result replaces the one taken at this edge; otherwise a taken
			// result leaves the output empty.
			if ((state_q == ST_TALLY) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					stale_q <= vote_stale;
					drop_q  <= !vote_stale && !chain[TABLE_DEPTH].hit &&
						!chain[TABLE_DEPTH].free;
					state_q <= ST_TALLY;
				end
				ST_TALLY: begin
					if (out_free) begin
						out_stale_q  <= stale_q;
						out_drop_q   <= drop_q;
						out_count_q  <= sel_count;
						out_quorum_q <= quorum;
						if (quorum) begin
							agreed_height_q <= vote_height_q;
							agreed_shift_q  <= vote_shift_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid          = out_valid_q;
	assign stale_vote         = out_stale_q;
	assign table_full_drop    = out_drop_q;
	assign vote_count         = out_count_q;
	assign quorum_reached     = out_quorum_q;
	assign agreed_height      = agreed_height_q;
	assign agreed_shift_index = agreed_shift_q;

endmodule
